[rtl/core/i2cmbs_pkg.sv]
package i2cmbs_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int BUS_CLEAR_TRIES = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam int FUNC_W  = 3;
    localparam int PHASE_W = 3;
    localparam int COUNT_W = 4;
    localparam int RETRY_W = 2;

    // func codes; OP_IDLE doubles as the tick code on the input side
    typedef enum logic [FUNC_W-1:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6,
        OP_WAIT  = 3'd7
    } op_t;

    // classified input item as it sits in the queue
    typedef struct packed {
        logic                 is_cmd;
        op_t                  op;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 sda_in;
    } item_t;

    typedef struct packed {
        logic                 rejected;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 ok;
        logic                 done_res;
        logic                 sda_level;
        logic                 scl_level;
    } result_t;

endpackage

[rtl/core/i2c_master_bit_sequencer_core.sv]
// I2C master pin sequencer. Send one command (s_tuser = start, stop, write,
// read, ack, nack or wait-ack) while idle, then one tick item (s_tuser = 0)
// per bus delay point with the sampled SDA level in s_tdata[8]. Every input
// item returns exactly one result item carrying the SCL/SDA levels to drive,
// and on the finishing tick done, ok and the received byte. Commands sent
// while busy come back flagged rejected and are otherwise ignored. The block
// sustains one item per clock while m_tready is high: a two-entry input queue
// feeds a sequencer that retires one item per cycle into an output register,
// and a result waiting with m_tready low stalls the sequencer. Each result
// item is registered: its input passes the queue slot, then the output register.
module i2c_master_bit_sequencer_core
    import i2cmbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = i2cmbs_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] tx_byte, [8] sda_in, [15:9] zero
    input  logic [2:0]  s_tuser,  // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // [0] scl_level, [1] sda_level, [2] done_res,
                                  // [3] ok, [11:4] rx_byte, [12] rejected,
                                  // [15:13] zero
);

    logic    q_valid;
    logic    q_pop;
    item_t   q_item;
    result_t result;

    i2cmbs_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (s_tuser),
        .s_tx_byte (s_tdata[7:0]),
        .s_sda_in  (s_tdata[8]),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    i2cmbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {3'b000, result.rejected, result.rx_byte, result.ok,
                      result.done_res, result.sda_level, result.scl_level};

endmodule

[rtl/core/i2cmbs_front.sv]
module i2cmbs_front
    import i2cmbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = i2cmbs_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [BYTE_BITS-1:0] s_tx_byte,
    input  logic                 s_sda_in,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    item_t            in_item;
    logic             push;
    logic             pop;

    always_comb begin
        in_item.is_cmd  = (s_func != OP_IDLE);
        in_item.op      = op_t'(s_func);
        in_item.tx_byte = s_tx_byte;
        in_item.sda_in  = s_sda_in;
    end

    assign s_tready = (count_reg != CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/core/i2cmbs_back.sv]
module i2cmbs_back
    import i2cmbs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_result
);

    localparam logic [COUNT_W-1:0] BITS_END  = COUNT_W'(BYTE_BITS);
    localparam logic [RETRY_W-1:0] RETRY_MAX = RETRY_W'(BUS_CLEAR_TRIES);

    op_t                  op_reg, op_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [COUNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [RETRY_W-1:0]   retry_reg, retry_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 m_valid_reg;
    result_t              res_reg, res_next;
    logic                 step_done;
    logic                 step_ok;
    logic                 step_rej;

    // a new item may enter whenever the output slot is free or draining
    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;

    // next state
    always_comb begin
        op_next      = op_reg;
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        retry_next   = retry_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        step_done    = 1'b0;
        step_ok      = 1'b1;
        step_rej     = 1'b0;
        if (q_pop) begin
            if (q_item.is_cmd) begin
                if (op_reg == OP_IDLE) begin
                    op_next      = q_item.op;
                    phase_next   = '0;
                    bit_cnt_next = '0;
                    retry_next   = '0;
                    shift_next   = '0;
                    case (q_item.op)
                        OP_START: sda_next = 1'b1;
                        OP_STOP:  sda_next = 1'b0;
                        OP_WRITE: begin
                            scl_next   = 1'b0;
                            shift_next = q_item.tx_byte;
                        end
                        OP_READ: begin
                            sda_next = 1'b1;
                            scl_next = 1'b0;
                        end
                        OP_ACK:   sda_next = 1'b0;
                        OP_NACK:  sda_next = 1'b1;
                        default:  scl_next = 1'b0;
                    endcase
                end else begin
                    step_rej = 1'b1;
                end
            end else begin
                case (op_reg)
                    OP_START: begin
                        if (phase_reg == 3'd0) begin
                            if (!q_item.sda_in && retry_reg < RETRY_MAX) begin
                                retry_next = retry_reg + 1'b1;
                            end else begin
                                scl_next   = 1'b1;
                                phase_next = 3'd1;
                            end
                        end else if (phase_reg == 3'd1) begin
                            if (!q_item.sda_in) begin
                                step_ok   = 1'b0;
                                step_done = 1'b1;
                            end else begin
                                sda_next   = 1'b0;
                                phase_next = 3'd2;
                            end
                        end else begin
                            step_done = 1'b1;
                            if (q_item.sda_in) begin
                                step_ok = 1'b0;
                            end else begin
                                scl_next = 1'b0;
                            end
                        end
                    end
                    OP_STOP: begin
                        case (phase_reg)
                            3'd0: begin
                                scl_next   = 1'b0;
                                phase_next = 3'd1;
                            end
                            3'd1: begin
                                scl_next   = 1'b1;
                                phase_next = 3'd2;
                            end
                            3'd2: begin
                                sda_next   = 1'b1;
                                phase_next = 3'd3;
                            end
                            3'd3: begin
                                // bus-clear pulse while a slave still holds SDA
                                if (!q_item.sda_in && retry_reg < RETRY_MAX) begin
                                    retry_next = retry_reg + 1'b1;
                                    scl_next   = 1'b0;
                                    phase_next = 3'd4;
                                end else begin
                                    step_done = 1'b1;
                                end
                            end
                            default: begin
                                scl_next   = 1'b1;
                                phase_next = 3'd3;
                            end
                        endcase
                    end
                    OP_WRITE: begin
                        if (phase_reg == 3'd0) begin
                            sda_next   = shift_reg[BYTE_BITS-1];
                            shift_next = {shift_reg[BYTE_BITS-2:0], 1'b0};
                            phase_next = 3'd1;
                        end else if (phase_reg == 3'd1) begin
                            scl_next   = 1'b1;
                            phase_next = 3'd2;
                        end else begin
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            scl_next     = 1'b0;
                            if (bit_cnt_next < BITS_END) begin
                                phase_next = 3'd0;
                            end else begin
                                step_done = 1'b1;
                            end
                        end
                    end
                    OP_READ: begin
                        if (phase_reg == 3'd0) begin
                            scl_next   = 1'b1;
                            phase_next = 3'd1;
                        end else begin
                            shift_next   = {shift_reg[BYTE_BITS-2:0], q_item.sda_in};
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            scl_next     = 1'b0;
                            if (bit_cnt_next < BITS_END) begin
                                phase_next = 3'd0;
                            end else begin
                                step_done = 1'b1;
                            end
                        end
                    end
                    OP_ACK, OP_NACK: begin
                        case (phase_reg)
                            3'd0: begin
                                scl_next   = 1'b0;
                                phase_next = 3'd1;
                            end
                            3'd1: begin
                                scl_next   = 1'b1;
                                phase_next = 3'd2;
                            end
                            3'd2: begin
                                scl_next   = 1'b0;
                                phase_next = 3'd3;
                            end
                            default: step_done = 1'b1;
                        endcase
                    end
                    OP_WAIT: begin
                        if (phase_reg == 3'd0) begin
                            sda_next   = 1'b1;
                            phase_next = 3'd1;
                        end else if (phase_reg == 3'd1) begin
                            scl_next   = 1'b1;
                            phase_next = 3'd2;
                        end else begin
                            scl_next  = 1'b0;
                            step_ok   = !q_item.sda_in;
                            step_done = 1'b1;
                        end
                    end
                    default: ; // tick while idle: nothing moves
                endcase
                if (step_done) begin
                    op_next    = OP_IDLE;
                    phase_next = '0;
                end
            end
        end
    end

    // result fields
    always_comb begin
        res_next.scl_level = scl_next;
        res_next.sda_level = sda_next;
        res_next.done_res  = step_done;
        res_next.ok        = step_done && step_ok;
        res_next.rx_byte   = (step_done && op_reg == OP_READ) ? shift_next : '0;
        res_next.rejected  = step_rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= OP_IDLE;
            phase_reg   <= '0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            retry_reg   <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            op_reg      <= op_next;
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            retry_reg   <= retry_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

    a_reject_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.is_cmd && op_reg != OP_IDLE)
            |=> ($stable(op_reg) && $stable(phase_reg) && $stable(shift_reg)))
        else $error("rejected command changed sequencer state");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && step_done) |=> (op_reg == OP_IDLE && phase_reg == '0))
        else $error("sequencer not idle after done");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= BITS_END)
        else $error("bit count beyond byte length");

    a_done_not_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(res_reg.done_res && res_reg.rejected))
        else $error("result flagged both done and rejected");

    a_idle_tick_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_item.is_cmd && op_reg == OP_IDLE) |-> !step_done)
        else $error("idle tick produced done");

endmodule
